// ===== sv/pida_pkg.sv =====
// Shared constants, request and status codes, and cell control type for the insert/delete array.
package pida_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned OP_W      = 3;
	localparam int unsigned STATUS_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_INSERT     = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_POP_FRONT  = 3'd4,
		OP_REMOVE_AT  = 3'd5,
		OP_READ       = 3'd6,
		OP_WRITE      = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Broadcast to every cell for one accepted request
	typedef struct packed {
		logic open_gap;   // cells above the target take their lower neighbor
		logic close_gap;  // cells at and above the target take their upper neighbor
		logic put;        // the target cell takes the request word
	} cell_ctrl_t;

endpackage

// ===== sv/pida_cell.sv =====
// One list entry: holds a word and shifts to or from its neighbors on insert and removal.
module pida_cell #(
	parameter int unsigned CNT_W = 7,
	parameter int unsigned INDEX = 0
) (
	input  logic                         clk,
	input  pida_pkg::cell_ctrl_t         ctrl,
	input  logic [CNT_W-1:0]             pos,
	input  logic [pida_pkg::WORD_W-1:0]  value,
	input  logic [pida_pkg::WORD_W-1:0]  left,
	input  logic [pida_pkg::WORD_W-1:0]  right,
	output logic [pida_pkg::WORD_W-1:0]  word,
	output logic [pida_pkg::WORD_W-1:0]  hit_word
);
	import pida_pkg::*;

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [WORD_W-1:0] data_q;
	logic              at_pos;
	logic              above_pos;

	assign at_pos    = (pos == IDX);
	assign above_pos = (IDX > pos);

	// Shift, load or hold the entry
	always_ff @(posedge clk) begin
		priority if (ctrl.close_gap && (at_pos || above_pos)) begin
			data_q <= right;
		end else if (ctrl.put && at_pos) begin
			data_q <= value;
		end else if (ctrl.open_gap && above_pos) begin
			data_q <= left;
		end else begin
			data_q <= data_q;
		end
	end

	assign word     = data_q;
	// Offer the entry to the read tree only when addressed
	assign hit_word = at_pos ? data_q : '0;

endmodule

// ===== sv/pida_or_group.sv =====
// Registered OR of a group of addressed cell words: first level of the read tree.
module pida_or_group #(
	parameter int unsigned N = 8
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [pida_pkg::WORD_W-1:0]  words [N],
	output logic [pida_pkg::WORD_W-1:0]  acc_s1
);
	import pida_pkg::*;

	logic [WORD_W-1:0] acc;

	// Combine the group; at most one word is nonzero
	always_comb begin
		acc = '0;
		for (int unsigned k = 0; k < N; k++) begin
			acc = acc | words[k];
		end
	end

	// Capture on request transfer
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s1 <= acc;
		end
	end

endmodule

// ===== sv/positional_insert_delete_array.sv =====
// Top level of the insert/delete array: request decode, cell row, read tree and result register.
//
// An ordered list of up to DEPTH signed 32-bit words kept in a row of cells, one entry per
// cell, with a count of entries held. A request (push back/front, insert, pop back/front,
// remove, read, write) is checked against the count, and on success every cell shifts,
// loads or holds in the clock edge that transfers the request, so a new request can follow
// at once: sustained rate one request per cycle while the result side does not stall. The
// result (read word, new count, status) passes the s1 registers and then the result
// register, which loads when it is empty or being taken: in the transfer cycle the addressed
// cell word runs through a registered OR of groups of eight cells, and the groups then
// combine into the result register. Rejected requests leave the list unchanged and return
// status full, index out of range or empty. Entries come up undefined after reset and need
// no clearing; only entries below the count are ever read.
module positional_insert_delete_array #(
	parameter int unsigned DEPTH = pida_pkg::DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [pida_pkg::OP_W-1:0]             op,
	input  logic [$clog2(DEPTH+1)-1:0]            position,
	input  logic signed [pida_pkg::WORD_W-1:0]    value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pida_pkg::WORD_W-1:0]    read_word,
	output logic [$clog2(DEPTH+1)-1:0]            count,
	output logic [pida_pkg::STATUS_W-1:0]         status
);
	import pida_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned GRP_N = 8;
	localparam int unsigned NGRP  = (DEPTH + GRP_N - 1) / GRP_N;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic             in_fire;
	logic             s1_adv;
	logic [CNT_W-1:0] held_q;
	op_t              req_op;
	status_t          req_status;
	logic [CNT_W-1:0] held_nxt;
	logic [CNT_W-1:0] tgt_pos;
	logic             req_ok;
	logic             is_full;
	logic             is_empty;
	cell_ctrl_t       ctrl;
	cell_ctrl_t       ctrl_dec;

	logic [WORD_W-1:0] words     [DEPTH];
	logic [WORD_W-1:0] hit_words [NGRP*GRP_N];
	logic [WORD_W-1:0] grp_s1    [NGRP];
	logic [WORD_W-1:0] grp_or;

	logic             v_s1_q;
	logic [CNT_W-1:0] count_s1;
	status_t          status_s1;
	logic             rd_ok_s1;

	logic                     out_valid_q;
	logic [WORD_W-1:0]        read_word_q;
	logic [CNT_W-1:0]         count_q;
	status_t                  status_q;

	assign req_op   = op_t'(op);
	assign is_full  = (held_q == FULL_CNT);
	assign is_empty = (held_q == '0);

	// Decode the request: status, target position, new count and cell action
	always_comb begin
		req_status = ST_OK;
		tgt_pos    = position;
		held_nxt   = held_q;
		ctrl_dec   = '0;
		unique case (req_op)
			OP_PUSH_BACK: begin
				tgt_pos = held_q;
				if (is_full) begin
					req_status = ST_FULL;
				end else begin
					held_nxt     = held_q + 1'b1;
					ctrl_dec.put = 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				tgt_pos = '0;
				if (is_full) begin
					req_status = ST_FULL;
				end else begin
					held_nxt          = held_q + 1'b1;
					ctrl_dec.put      = 1'b1;
					ctrl_dec.open_gap = 1'b1;
				end
			end
			OP_INSERT: begin
				priority if (position > held_q) begin
					req_status = ST_RANGE;
				end else if (is_full) begin
					req_status = ST_FULL;
				end else begin
					held_nxt          = held_q + 1'b1;
					ctrl_dec.put      = 1'b1;
					ctrl_dec.open_gap = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (is_empty) begin
					req_status = ST_EMPTY;
				end else begin
					held_nxt = held_q - 1'b1;
				end
			end
			OP_POP_FRONT: begin
				tgt_pos = '0;
				if (is_empty) begin
					req_status = ST_EMPTY;
				end else begin
					held_nxt           = held_q - 1'b1;
					ctrl_dec.close_gap = 1'b1;
				end
			end
			OP_REMOVE_AT: begin
				priority if (is_empty) begin
					req_status = ST_EMPTY;
				end else if (position >= held_q) begin
					req_status = ST_RANGE;
				end else begin
					held_nxt           = held_q - 1'b1;
					ctrl_dec.close_gap = 1'b1;
				end
			end
			OP_READ: begin
				if (position >= held_q) begin
					req_status = ST_RANGE;
				end
			end
			OP_WRITE: begin
				if (position >= held_q) begin
					req_status = ST_RANGE;
				end else begin
					ctrl_dec.put = 1'b1;
				end
			end
			default: begin
				req_status = ST_RANGE;
			end
		endcase
	end

	assign req_ok   = (req_status == ST_OK);
	assign in_fire  = in_valid && in_ready;
	assign s1_adv   = v_s1_q && (!out_valid_q || out_ready);
	assign in_ready = !v_s1_q || s1_adv;
	assign ctrl     = in_fire ? ctrl_dec : '0;

	// Row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid
			assign left_w = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = words[i];
		end else begin : g_inner
			assign right_w = words[i+1];
		end
		pida_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.pos      (tgt_pos),
			.value    (value),
			.left     (left_w),
			.right    (right_w),
			.word     (words[i]),
			.hit_word (hit_words[i])
		);
	end

	// Pad the last group of the read tree
	for (genvar k = DEPTH; k < NGRP * GRP_N; k++) begin : g_pad
		assign hit_words[k] = '0;
	end

	// First level of the read tree
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		pida_or_group #(
			.N (GRP_N)
		) u_grp (
			.clk    (clk),
			.en     (in_fire),
			.words  (hit_words[g*GRP_N +: GRP_N]),
			.acc_s1 (grp_s1[g])
		);
	end

	// Second level of the read tree
	always_comb begin
		grp_or = '0;
		for (int unsigned g = 0; g < NGRP; g++) begin
			grp_or = grp_or | grp_s1[g];
		end
	end

	// Update the count on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (in_fire) begin
			held_q <= held_nxt;
		end
	end

	// Hold the request result while the read tree settles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (in_fire) begin
			v_s1_q <= 1'b1;
		end else if (s1_adv) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			count_s1  <= held_nxt;
			status_s1 <= req_status;
			rd_ok_s1  <= (req_op == OP_READ) && req_ok;
		end
	end

	// Result register: advance when empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			read_word_q <= rd_ok_s1 ? grp_or : '0;
			count_q     <= count_s1;
			status_q    <= status_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign read_word = read_word_q;
	assign count     = count_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FULL_CNT)
		else $error("count exceeds depth");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !req_ok |=> $stable(held_q))
		else $error("rejected request changed the count");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && req_ok && (req_op == OP_PUSH_BACK || req_op == OP_PUSH_FRONT ||
		req_op == OP_INSERT) |=> held_q == $past(held_q) + 1'b1)
		else $error("accepted insert did not grow the count");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_EMPTY |-> count_q == '0)
		else $error("empty status with nonzero count");

	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> read_word_q == '0)
		else $error("rejected request returned a nonzero word");
`endif

endmodule

// ===== dv/list_result_checker.sv =====
// Result checker for the insert/delete array: tracks the list, predicts each result, compares.
`timescale 1ns / 1ps
module list_result_checker #(
	parameter int unsigned DEPTH = pida_pkg::DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic [pida_pkg::OP_W-1:0]             op,
	input  logic [$clog2(DEPTH+1)-1:0]            position,
	input  logic signed [pida_pkg::WORD_W-1:0]    value,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [pida_pkg::WORD_W-1:0]    read_word,
	input  logic [$clog2(DEPTH+1)-1:0]            count,
	input  logic [pida_pkg::STATUS_W-1:0]         status,
	output int                                    mismatches,
	output int                                    outstanding,
	output int                                    checked
);
	import pida_pkg::*;

	localparam int PW = $clog2(DEPTH+1);

	typedef struct packed {
		logic signed [WORD_W-1:0] word;
		logic [PW-1:0]            len;
		status_t                  st;
	} list_result_t;

	logic signed [WORD_W-1:0] list_words [DEPTH];
	int unsigned              list_len;
	list_result_t             awaited_results [$];
	list_result_t             oldest;
	int                       bad_cnt;
	int                       good_cnt;

	// Apply one request to the tracked list and return the result it should produce
	function automatic list_result_t predict_list_result(op_t req, int unsigned idx,
			logic signed [WORD_W-1:0] word);
		list_result_t res;
		int unsigned  i;
		res.word = '0;
		res.st   = ST_OK;
		case (req)
			OP_PUSH_BACK: begin
				if (list_len >= DEPTH) res.st = ST_FULL;
				else begin
					list_words[list_len] = word;
					list_len++;
				end
			end
			OP_PUSH_FRONT, OP_INSERT: begin
				if (req == OP_PUSH_FRONT) idx = 0;
				if (idx > list_len) res.st = ST_RANGE;
				else if (list_len >= DEPTH) res.st = ST_FULL;
				else begin
					// open a gap at the target, later entries move up
					for (i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
					list_words[idx] = word;
					list_len++;
				end
			end
			OP_POP_BACK: begin
				if (list_len == 0) res.st = ST_EMPTY;
				else list_len--;
			end
			OP_POP_FRONT, OP_REMOVE_AT: begin
				if (req == OP_POP_FRONT) idx = 0;
				if (list_len == 0) res.st = ST_EMPTY;
				else if (idx >= list_len) res.st = ST_RANGE;
				else begin
					// close the gap, later entries move down
					for (i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			OP_READ: begin
				if (idx >= list_len) res.st = ST_RANGE;
				else res.word = list_words[idx];
			end
			default: begin
				if (idx >= list_len) res.st = ST_RANGE;
				else list_words[idx] = word;
			end
		endcase
		res.len = PW'(list_len);
		return res;
	endfunction

	// Compare result transfers first, then record the request transfer of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			awaited_results.delete();
			bad_cnt  = 0;
			good_cnt = 0;
			mismatches  <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					bad_cnt++;
					if (bad_cnt <= 10)
						$display("%0t: result with none awaited: word %0d count %0d status %0d",
							$realtime, read_word, count, status);
				end else begin
					oldest = awaited_results[0];
					awaited_results.delete(0);
					if (read_word !== oldest.word || count !== oldest.len
							|| status !== oldest.st) begin
						bad_cnt++;
						if (bad_cnt <= 10)
							$display("%0t: got word %0d count %0d status %0d, %s %0d %0d %0d",
								$realtime, read_word, count, status, "expected",
								oldest.word, oldest.len, oldest.st);
					end else begin
						good_cnt++;
					end
				end
			end
			if (in_valid && in_ready)
				awaited_results.insert(awaited_results.size(),
					predict_list_result(op_t'(op), position, value));
			mismatches  <= bad_cnt;
			outstanding <= awaited_results.size();
			checked     <= good_cnt + bad_cnt;
		end
	end

endmodule

// ===== dv/positional_insert_delete_array_tb.sv =====
// Testbench top for the insert/delete array: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module positional_insert_delete_array_tb;
	import pida_pkg::*;

	localparam int unsigned DEPTH        = DEPTH_DEF;
	localparam int          PW           = $clog2(DEPTH+1);
	localparam int          RANDOM_ITEMS = 1200;
	localparam int          CYCLE_LIMIT  = 300000;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [OP_W-1:0]            op;
	logic [PW-1:0]              position;
	logic signed [WORD_W-1:0]   value;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [WORD_W-1:0]   read_word;
	logic [PW-1:0]              count;
	logic [STATUS_W-1:0]        status;

	int          mismatches;
	int          outstanding;
	int          checked;
	int          send_idle_pct = 7;
	int          recv_idle_pct = 62;
	int unsigned list_len      = 0;
	int          requests_sent = 0;
	int          fills         = 0;
	int          drains        = 0;
	int          cycles        = 0;

	positional_insert_delete_array #(.DEPTH(DEPTH)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_word (read_word),
		.count     (count),
		.status    (status)
	);

	list_result_checker #(.DEPTH(DEPTH)) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_word   (read_word),
		.count       (count),
		.status      (status),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results awaited", cycles, outstanding);
			$display("positional_insert_delete_array: mismatch");
			$finish;
		end
	end

	// Present one request, hold it until the transfer, and track the list length
	task automatic send_request(input op_t req, input int unsigned idx,
			input logic signed [WORD_W-1:0] word);
		int unsigned prev_len;
		prev_len = list_len;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		op       <= req;
		position <= PW'(idx);
		value    <= word;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		requests_sent++;
		case (req)
			OP_PUSH_BACK, OP_PUSH_FRONT: if (list_len < DEPTH) list_len++;
			OP_INSERT: if (idx <= list_len && list_len < DEPTH) list_len++;
			OP_POP_BACK, OP_POP_FRONT: if (list_len > 0) list_len--;
			OP_REMOVE_AT: if (idx < list_len) list_len--;
			default: ;
		endcase
		if (list_len == DEPTH && prev_len != DEPTH) fills++;
		if (list_len == 0 && prev_len != 0) drains++;
	endtask

	// Hold off new requests until every awaited result has come back
	task automatic wait_results_done();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		op_t                      req;
		int unsigned              idx;
		logic signed [WORD_W-1:0] word;
		bit                       grow;
		int                       r;

		arst_n    = 1'b0;
		in_valid  <= 1'b0;
		op        <= OP_READ;
		position  <= '0;
		value     <= '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: empty list rejections
		send_request(OP_POP_BACK, 0, 0);
		send_request(OP_POP_FRONT, 127, 0);
		send_request(OP_REMOVE_AT, 0, 0);
		send_request(OP_READ, 0, 0);
		send_request(OP_WRITE, 0, -1);
		send_request(OP_INSERT, 1, 5);
		// build a short list with extreme words, append by insert at the end
		send_request(OP_INSERT, 0, 32'sh7fff_ffff);
		send_request(OP_PUSH_BACK, 0, 32'sh8000_0000);
		send_request(OP_PUSH_FRONT, 0, -1);
		send_request(OP_INSERT, 3, 0);
		send_request(OP_INSERT, 1, 32'sh5555_5555);
		// reads at both ends and one past the end
		send_request(OP_READ, 0, 0);
		send_request(OP_READ, 4, 0);
		send_request(OP_READ, 5, 0);
		send_request(OP_WRITE, 2, 32'shaaaa_aaaa);
		send_request(OP_READ, 2, 0);
		// removals, in range and past the end
		send_request(OP_REMOVE_AT, 5, 0);
		send_request(OP_REMOVE_AT, 1, 0);
		send_request(OP_POP_FRONT, 0, 0);
		send_request(OP_POP_BACK, 0, 0);
		// positions far out of range
		send_request(OP_READ, 127, 0);
		send_request(OP_INSERT, 127, 1);
		send_request(OP_REMOVE_AT, DEPTH, 0);
		send_request(OP_WRITE, DEPTH, 1);

		// Random: swing between growing to full and shrinking to empty
		grow = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 6) wait_results_done();
			if (n == RANDOM_ITEMS / 3) begin
				wait_results_done();
				send_idle_pct = 62;
				recv_idle_pct = 7;
			end
			if (n == 2 * RANDOM_ITEMS / 3) begin
				wait_results_done();
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			// flip direction at the ends, now and then in the middle
			if (grow && list_len == DEPTH && $urandom_range(3) == 0) grow = 1'b0;
			else if (!grow && list_len == 0 && $urandom_range(3) == 0) grow = 1'b1;
			else if ($urandom_range(99) < 2) grow = !grow;

			r = $urandom_range(99);
			if (grow) begin
				if (r < 20) req = OP_PUSH_BACK;
				else if (r < 35) req = OP_PUSH_FRONT;
				else if (r < 60) req = OP_INSERT;
				else if (r < 65) req = OP_POP_BACK;
				else if (r < 70) req = OP_POP_FRONT;
				else if (r < 75) req = OP_REMOVE_AT;
				else if (r < 88) req = OP_READ;
				else req = OP_WRITE;
			end else begin
				if (r < 5) req = OP_PUSH_BACK;
				else if (r < 10) req = OP_PUSH_FRONT;
				else if (r < 15) req = OP_INSERT;
				else if (r < 35) req = OP_POP_BACK;
				else if (r < 50) req = OP_POP_FRONT;
				else if (r < 75) req = OP_REMOVE_AT;
				else if (r < 88) req = OP_READ;
				else req = OP_WRITE;
			end

			// mostly legal positions, some anywhere in the field
			r = $urandom_range(99);
			if (req == OP_INSERT && r < 85) idx = $urandom_range(list_len);
			else if ((req == OP_REMOVE_AT || req == OP_READ || req == OP_WRITE)
					&& list_len > 0 && r < 85)
				idx = $urandom_range(list_len - 1);
			else idx = $urandom_range(127);

			case ($urandom_range(15))
				0: word = 32'sh7fff_ffff;
				1: word = 32'sh8000_0000;
				2: word = 0;
				3: word = -1;
				default: word = $urandom();
			endcase

			send_request(req, idx, word);
		end

		wait_results_done();
		repeat (8) @(posedge clk);
		$display("%0d requests, %0d results checked; list filled %0d times, emptied %0d times",
			requests_sent, checked, fills, drains);
		$display("idle mix: light sender with heavy result stalls, reversed, then none");
		if (mismatches == 0 && outstanding == 0)
			$display("positional_insert_delete_array: match");
		else
			$display("positional_insert_delete_array: mismatch");
		$finish;
	end

endmodule
